@@ src/fuc_pkg.sv @@
// Package for the first unique character stream block: sequencer states and character codes.
`default_nettype none
package fuc_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_RDHEAD,
        S_CHECK,
        S_EMIT
    } t_state;

    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [1:0] CNT_ZERO   = 2'd0;
    localparam logic [1:0] CNT_REPEAT = 2'd2;

endpackage
`default_nettype wire

@@ src/fuc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fuc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    input  wire                      i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ src/first_unique_char_stream.sv @@
// Top level: first non-repeating lowercase letter of a character stream.
// A letter beat passes COUNT, then RDHEAD and CHECK for each queue head read, popping heads that
// repeat, then EMIT (RDHEAD goes to EMIT if the queue is empty); other bytes give no result.
// Flow: one beat at a time; a letter holds the input off until its result is registered,
// other bytes are taken every cycle while idle; a pending result stalls the sequencer in EMIT.
// Reset: synchronous, active low; clears counts, queue pointers, occupancy and the output valid flag.
`default_nettype none
module first_unique_char_stream
    import fuc_pkg::*;
#(
    parameter int ALPHABET_SIZE = 26,
    parameter int QUEUE_DEPTH   = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] char_code
    input  wire         i_s_tuser,   // [0] starts_string
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [0] has_unique, [8:1] unique_char, [15:9] zero
);

    localparam int LW = $clog2(ALPHABET_SIZE);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    t_state        r_state, n_state;
    logic [1:0]    r_counts [ALPHABET_SIZE];
    logic [1:0]    n_counts [ALPHABET_SIZE];
    logic [QW-1:0] r_head, n_head, r_tail, n_tail;
    logic [OW-1:0] r_occ, n_occ;
    logic [LW-1:0] r_idx, n_idx, r_letter, n_letter;
    logic          r_out_valid, n_out_valid;
    logic          r_out_has, n_out_has;
    logic [7:0]    r_out_char, n_out_char;

    logic          s_fire, m_fire;
    logic [8:0]    in_diff;
    logic          in_letter;
    logic [LW-1:0] cnt_addr, rd_data;
    logic [1:0]    cnt_val;
    logic          wr_en, rd_en;
    logic [QW-1:0] head_next, tail_next;

    fuc_ram #(
        .WIDTH(LW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(r_idx),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_head),
        .o_rd_data(rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid & o_s_tready;
    assign m_fire     = r_out_valid & i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_char, r_out_has};

    assign in_diff   = {1'b0, i_s_tdata} - {1'b0, CHAR_A};
    assign in_letter = !in_diff[8] && (in_diff[7:0] < 8'(ALPHABET_SIZE));

    assign head_next = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    assign cnt_addr = (r_state == S_CHECK) ? rd_data : r_idx;
    assign cnt_val  = r_counts[cnt_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counts    <= '{default: CNT_ZERO};
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counts    <= n_counts;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_letter   <= n_letter;
        r_out_has  <= n_out_has;
        r_out_char <= n_out_char;
    end

    always_comb begin
        n_state     = r_state;
        n_counts    = r_counts;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_letter    = r_letter;
        n_out_valid = r_out_valid & ~m_fire;
        n_out_has   = r_out_has;
        n_out_char  = r_out_char;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_idx = in_diff[LW-1:0];
                    if (i_s_tuser) begin
                        n_counts = '{default: CNT_ZERO};
                        n_head   = '0;
                        n_tail   = '0;
                        n_occ    = '0;
                    end
                    if (in_letter) begin
                        n_state = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                if (cnt_val != CNT_REPEAT) begin
                    n_counts[r_idx] = cnt_val + 2'd1;
                end
                if (cnt_val == CNT_ZERO && r_occ < OW'(QUEUE_DEPTH)) begin
                    wr_en  = 1'b1;
                    n_tail = tail_next;
                    n_occ  = r_occ + 1'b1;
                end
                n_state = S_RDHEAD;
            end
            S_RDHEAD: begin
                if (r_occ == '0) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (cnt_val > 2'd1) begin
                    n_head  = head_next;
                    n_occ   = r_occ - 1'b1;
                    n_state = S_RDHEAD;
                end else begin
                    n_letter = rd_data;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_has   = (r_occ != '0);
                    n_out_char  = (r_occ != '0) ? CHAR_A + 8'(r_letter) : 8'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) |-> (r_occ == '0 || r_occ == OW'(QUEUE_DEPTH)))
        else $error("queue pointers disagree with occupancy");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_char == 8'd0))
        else $error("none result carries a letter");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_char)))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

@@ verif/tb_first_unique_char_stream.sv @@
`timescale 1ns / 1ps
// Testbench for first_unique_char_stream: directed and random letter strings, scoreboard checked.
module tb_first_unique_char_stream;
    import fuc_pkg::*;

    localparam int ALPHA_SIZE   = 26;
    localparam int ORDER_DEPTH  = 32;
    localparam int RAND_BEATS   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] letter;
        logic       found;
    } t_answer;

    class uniq_scoreboard;
        logic [1:0] letter_cnt [ALPHA_SIZE];
        logic [4:0] order_q [$];
        t_answer    answer_q [$];
        int         errors;
        int         checked;
        int         deepest;

        function new();
            clear();
            errors  = 0;
            checked = 0;
            deepest = 0;
        endfunction

        function void clear();
            foreach (letter_cnt[i]) letter_cnt[i] = CNT_ZERO;
            order_q.delete();
        endfunction

        function void note_char(logic [7:0] ch, logic starts);
            logic [4:0] idx;
            t_answer    ans;
            if (starts)
                clear();
            if (ch < CHAR_A || ch - CHAR_A >= ALPHA_SIZE)
                return;
            idx = 5'(ch - CHAR_A);
            if (letter_cnt[idx] < CNT_REPEAT)
                letter_cnt[idx]++;
            if (letter_cnt[idx] == 2'd1 && order_q.size() < ORDER_DEPTH)
                order_q.push_back(idx);
            if (order_q.size() > deepest)
                deepest = order_q.size();
            while (order_q.size() > 0 && letter_cnt[order_q[0]] == CNT_REPEAT)
                void'(order_q.pop_front());
            ans = '0;
            if (order_q.size() > 0) begin
                ans.found  = 1'b1;
                ans.letter = CHAR_A + 8'(order_q[0]);
            end
            answer_q.push_back(ans);
        endfunction

        function void check_beat(logic [15:0] beat);
            t_answer got;
            t_answer want;
            got = beat;
            checked++;
            if (answer_q.size() == 0) begin
                errors++;
                $error("result beat %h with nothing expected", beat);
                return;
            end
            want = answer_q.pop_front();
            if (got.found !== want.found) begin
                errors++;
                $error("has_unique: expected %0d, got %0d", want.found, got.found);
            end
            if (got.letter !== want.letter) begin
                errors++;
                $error("unique_char: expected %h, got %h", want.letter, got.letter);
            end
            if (got.pad !== want.pad) begin
                errors++;
                $error("tdata pad: expected %h, got %h", want.pad, got.pad);
            end
        endfunction

        function int pending();
            return answer_q.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = '0;    // [7:0] char_code
    logic        i_s_tuser  = 1'b0;  // [0] starts_string
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;          // [0] has_unique, [8:1] unique_char, [15:9] zero

    uniq_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_go   = 1'b0;
    int cycles    = 0;
    int beats_sent   = 0;
    int letters_sent = 0;
    int starts_sent  = 0;

    first_unique_char_stream u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_beat(o_m_tdata);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_go = 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] ch, input logic starts);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tuser  <= starts;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_char(ch, starts);
        beats_sent++;
        if (starts)
            starts_sent++;
        if (ch >= CHAR_A && ch - CHAR_A < ALPHA_SIZE)
            letters_sent++;
    endtask

    task automatic park_sender();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_random_string();
        int kind;
        int len;
        int span;
        int base;
        logic [7:0] ch;
        kind = $urandom_range(9);
        if (kind < 6) begin
            // narrow alphabet so letters repeat often, a little noise mixed in
            span = ($urandom_range(3) == 0) ? ALPHA_SIZE : $urandom_range(1, 8);
            len  = $urandom_range(1, 30);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(15) == 0)
                    ch = $urandom_range(1) ? CHAR_SPACE : 8'($urandom_range(255));
                else
                    ch = CHAR_A + 8'($urandom_range(span - 1));
                send_beat(ch, i == 0);
            end
        end else if (kind < 8) begin
            // distinct run, then repeated in reverse: last repeat pops the whole queue
            span = $urandom_range(2, ALPHA_SIZE);
            base = $urandom_range(ALPHA_SIZE - 1);
            for (int i = 0; i < span; i++)
                send_beat(CHAR_A + 8'((base + i) % ALPHA_SIZE), i == 0);
            for (int i = span - 1; i >= 0; i--)
                send_beat(CHAR_A + 8'((base + i) % ALPHA_SIZE), 1'b0);
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int idle_tab  [4];
        int stall_tab [4];
        int target;
        idle_tab  = '{0, 54, 0, 21};
        stall_tab = '{0, 0, 54, 21};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(CHAR_A, 1'b1);
        send_beat(CHAR_A, 1'b0);                        // repeat -> none
        send_beat(CHAR_A, 1'b0);                        // count saturates
        send_beat(CHAR_A + 8'd1, 1'b0);
        send_beat(CHAR_SPACE, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(CHAR_A - 8'd1, 1'b0);
        send_beat(CHAR_A + 8'(ALPHA_SIZE), 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(CHAR_A + 8'd25, 1'b0);
        send_beat(CHAR_A + 8'd1, 1'b0);                 // head moves to z
        send_beat(CHAR_SPACE, 1'b1);                    // start on a space still clears
        send_beat(CHAR_A + 8'd25, 1'b0);
        send_beat(8'hFF, 1'b1);                         // start on a non-letter
        send_beat(CHAR_A + 8'd24, 1'b0);
        send_beat(CHAR_A + 8'd24, 1'b0);
        send_beat(CHAR_A + 8'd25, 1'b1);
        park_sender();

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = idle_tab[phase];
            stall_pct = stall_tab[phase];
            if (phase == 0)
                hold_go = 1'b1;
            target = beats_sent + RAND_BEATS / 4;
            while (beats_sent < target)
                send_random_string();
            park_sender();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats: %0d letters, %0d other bytes, %0d string starts.",
                 beats_sent, letters_sent, beats_sent - letters_sent, starts_sent);
        $display("Checked %0d results; longest letter queue %0d entries.",
                 sb.checked, sb.deepest);
        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
